[sv/yuv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Shared widths, fixed-point coefficients and stage-control type for the
// YUYV to RGB888 pixel-pair converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yuv2rgb_pkg;

    // Field widths
    localparam int unsigned PIX_W    = 8;   // luma, chroma and RGB channel bytes
    localparam int unsigned DIFF_W   = 9;   // signed chroma difference, -128..127
    localparam int unsigned COEF_W   = 18;  // signed holder for unsigned Q1.16 coefs
    localparam int unsigned SUM_W    = 26;  // signed channel sum at 2^-16 resolution
    localparam int unsigned FRAC_W   = 16;  // fraction bits of the channel sum
    localparam int unsigned INT_W    = SUM_W - FRAC_W - 1; // integer bits above sign
    localparam int unsigned SCALED_W = 2 * PIX_W;          // channel times scale numerator

    // Coefficients, real value times 65536 rounded to nearest
    localparam logic signed [COEF_W-1:0] C_KR  = 18'sd89831;   // 1.370705
    localparam logic signed [COEF_W-1:0] C_KGV = 18'sd45744;   // 0.698001
    localparam logic signed [COEF_W-1:0] C_KGU = 18'sd22127;   // 0.337633
    localparam logic signed [COEF_W-1:0] C_KB  = 18'sd113538;  // 1.732446

    // Output scaling: floor(c * 220 / 256)
    localparam logic [PIX_W-1:0] C_CHAN_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] C_SCALE_NUM = 8'd220;

    // Per-stage advance enables, handed from the top level to the datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage : yuv2rgb_pkg

`default_nettype wire

[sv/yuv2rgb_chroma_mul.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_chroma_mul
// First pipeline stage: removes the chroma offset and forms the four
// chroma products that both pixels of a pair share.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv2rgb_chroma_mul
    import yuv2rgb_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_en,
    input  wire  [PIX_W-1:0]              i_chroma_blue,
    input  wire  [PIX_W-1:0]              i_chroma_red,
    output logic signed [SUM_W-1:0]       o_prod_r,
    output logic signed [SUM_W-1:0]       o_prod_gv,
    output logic signed [SUM_W-1:0]       o_prod_gu,
    output logic signed [SUM_W-1:0]       o_prod_b
);

    logic signed [DIFF_W-1:0] du;
    logic signed [DIFF_W-1:0] dv;
    logic signed [SUM_W-1:0]  n_prod_r;
    logic signed [SUM_W-1:0]  n_prod_gv;
    logic signed [SUM_W-1:0]  n_prod_gu;
    logic signed [SUM_W-1:0]  n_prod_b;
    logic signed [SUM_W-1:0]  r_prod_r;
    logic signed [SUM_W-1:0]  r_prod_gv;
    logic signed [SUM_W-1:0]  r_prod_gu;
    logic signed [SUM_W-1:0]  r_prod_b;

    // Offset removal: x - 128 is the byte with its top bit flipped, read signed
    assign du = DIFF_W'(signed'({~i_chroma_blue[PIX_W-1], i_chroma_blue[PIX_W-2:0]}));
    assign dv = DIFF_W'(signed'({~i_chroma_red[PIX_W-1],  i_chroma_red[PIX_W-2:0]}));

    // Four constant multiplies, 18 x 9 bits each
    always_comb begin
        n_prod_r  = SUM_W'(C_KR)  * SUM_W'(dv);
        n_prod_gv = SUM_W'(C_KGV) * SUM_W'(dv);
        n_prod_gu = SUM_W'(C_KGU) * SUM_W'(du);
        n_prod_b  = SUM_W'(C_KB)  * SUM_W'(du);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_r  <= n_prod_r;
            r_prod_gv <= n_prod_gv;
            r_prod_gu <= n_prod_gu;
            r_prod_b  <= n_prod_b;
        end
    end

    assign o_prod_r  = r_prod_r;
    assign o_prod_gv = r_prod_gv;
    assign o_prod_gu = r_prod_gu;
    assign o_prod_b  = r_prod_b;

endmodule : yuv2rgb_chroma_mul

`default_nettype wire

[sv/yuv2rgb_pixel.sv]
// ----------------------------------------------------------------------------
// yuv2rgb_pixel
// Datapath for one pixel: luma capture, channel sums, then clamp to 0..255
// and scale by 220/256 into the output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv2rgb_pixel
    import yuv2rgb_pkg::*;
(
    input  wire                           i_clk,
    input  wire  t_stage_en               i_en,
    input  wire  [PIX_W-1:0]              i_luma,
    input  wire  signed [SUM_W-1:0]       i_prod_r,
    input  wire  signed [SUM_W-1:0]       i_prod_gv,
    input  wire  signed [SUM_W-1:0]       i_prod_gu,
    input  wire  signed [SUM_W-1:0]       i_prod_b,
    output logic [PIX_W-1:0]              o_red,
    output logic [PIX_W-1:0]              o_green,
    output logic [PIX_W-1:0]              o_blue
);

    logic [PIX_W-1:0]        r_luma;
    logic signed [SUM_W-1:0] luma_scaled;
    logic signed [SUM_W-1:0] n_sum_r;
    logic signed [SUM_W-1:0] n_sum_g;
    logic signed [SUM_W-1:0] n_sum_b;
    logic signed [SUM_W-1:0] r_sum_r;
    logic signed [SUM_W-1:0] r_sum_g;
    logic signed [SUM_W-1:0] r_sum_b;
    logic [PIX_W-1:0]        n_red;
    logic [PIX_W-1:0]        n_green;
    logic [PIX_W-1:0]        n_blue;
    logic [PIX_W-1:0]        r_red;
    logic [PIX_W-1:0]        r_green;
    logic [PIX_W-1:0]        r_blue;

    // Clamp a Q.16 sum to 0..255 (negative gives 0), then floor(c * 220 / 256)
    function automatic logic [PIX_W-1:0] chan_scale(input logic signed [SUM_W-1:0] sum);
        logic [INT_W-1:0]    whole;
        logic [PIX_W-1:0]    chan;
        logic [SCALED_W-1:0] scaled;
        whole = sum[SUM_W-2:FRAC_W];
        if (sum[SUM_W-1]) begin
            chan = '0;
        end else if (whole > INT_W'(C_CHAN_MAX)) begin
            chan = C_CHAN_MAX;
        end else begin
            chan = whole[PIX_W-1:0];
        end
        scaled = SCALED_W'(chan) * SCALED_W'(C_SCALE_NUM);
        return scaled[SCALED_W-1:PIX_W];
    endfunction

    // Stage 1: luma waits alongside the chroma products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_luma <= i_luma;
        end
    end

    // Stage 2: channel sums
    assign luma_scaled = signed'({2'b00, r_luma, {FRAC_W{1'b0}}});

    always_comb begin
        n_sum_r = luma_scaled + i_prod_r;
        n_sum_g = luma_scaled - i_prod_gv - i_prod_gu;
        n_sum_b = luma_scaled + i_prod_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
        end
    end

    // Stage 3: clamp and scale into the output registers
    always_comb begin
        n_red   = chan_scale(r_sum_r);
        n_green = chan_scale(r_sum_g);
        n_blue  = chan_scale(r_sum_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule : yuv2rgb_pixel

`default_nettype wire

[sv/yuyv_to_rgb888_converter.sv]
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_converter
// YUYV 4:2:2 group to two RGB888 pixels, scaled to 0..219 per channel.
//
// Input channel: one beat carries a packed group (first luma, blue chroma,
// second luma, red chroma) and a frame-end flag; it is taken on a clock edge
// with i_valid high and o_stall low. Output channel: one beat carries both
// pixels and the copied flag; it is taken with o_valid high and i_stall low.
// Three register stages: chroma products, channel sums, clamp and scale.
// A taken beat passes the chroma-product, channel-sum and output registers
// in that order before it is presented. Throughput is one group per clock
// while i_stall stays low; every stage holds its own valid bit and fills
// its slot whenever it is empty or the next stage moves on.
// A stalled receiver holds the output beat steady; upstream stages keep
// filling bubbles, and o_stall rises only once every stage holds a beat.
// The synchronous active-low reset empties the pipeline; no beat is
// presented until new input arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb888_converter
    import yuv2rgb_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Input beat
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [PIX_W-1:0]     i_luma_first,
    input  wire  [PIX_W-1:0]     i_chroma_blue,
    input  wire  [PIX_W-1:0]     i_luma_second,
    input  wire  [PIX_W-1:0]     i_chroma_red,
    input  wire                  i_frame_end,
    // Output beat
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [PIX_W-1:0]     o_red_first,
    output logic [PIX_W-1:0]     o_green_first,
    output logic [PIX_W-1:0]     o_blue_first,
    output logic [PIX_W-1:0]     o_red_second,
    output logic [PIX_W-1:0]     o_green_second,
    output logic [PIX_W-1:0]     o_blue_second,
    output logic                 o_frame_end_out
);

    t_stage_en               stage_en;
    logic                    r_valid_s1;
    logic                    r_valid_s2;
    logic                    r_valid_s3;
    logic                    r_frame_end_s1;
    logic                    r_frame_end_s2;
    logic                    r_frame_end_s3;
    logic signed [SUM_W-1:0] prod_r;
    logic signed [SUM_W-1:0] prod_gv;
    logic signed [SUM_W-1:0] prod_gu;
    logic signed [SUM_W-1:0] prod_b;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        stage_en.s3 = !r_valid_s3 || !i_stall;
        stage_en.s2 = !r_valid_s2 || stage_en.s3;
        stage_en.s1 = !r_valid_s1 || stage_en.s2;
    end

    assign o_stall = !stage_en.s1;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s1 <= 1'b0;
            r_valid_s2 <= 1'b0;
            r_valid_s3 <= 1'b0;
        end else begin
            if (stage_en.s1) r_valid_s1 <= i_valid;
            if (stage_en.s2) r_valid_s2 <= r_valid_s1;
            if (stage_en.s3) r_valid_s3 <= r_valid_s2;
        end
    end

    // Frame-end flag rides along with the data
    always_ff @(posedge i_clk) begin
        if (stage_en.s1) r_frame_end_s1 <= i_frame_end;
        if (stage_en.s2) r_frame_end_s2 <= r_frame_end_s1;
        if (stage_en.s3) r_frame_end_s3 <= r_frame_end_s2;
    end

    // Shared chroma products
    yuv2rgb_chroma_mul u_chroma_mul (
        .i_clk         (i_clk),
        .i_en          (stage_en.s1),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_prod_r      (prod_r),
        .o_prod_gv     (prod_gv),
        .o_prod_gu     (prod_gu),
        .o_prod_b      (prod_b)
    );

    // First pixel
    yuv2rgb_pixel u_pixel_first (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_luma    (i_luma_first),
        .i_prod_r  (prod_r),
        .i_prod_gv (prod_gv),
        .i_prod_gu (prod_gu),
        .i_prod_b  (prod_b),
        .o_red     (o_red_first),
        .o_green   (o_green_first),
        .o_blue    (o_blue_first)
    );

    // Second pixel
    yuv2rgb_pixel u_pixel_second (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_luma    (i_luma_second),
        .i_prod_r  (prod_r),
        .i_prod_gv (prod_gv),
        .i_prod_gu (prod_gu),
        .i_prod_b  (prod_b),
        .o_red     (o_red_second),
        .o_green   (o_green_second),
        .o_blue    (o_blue_second)
    );

    assign o_valid         = r_valid_s3;
    assign o_frame_end_out = r_frame_end_s3;

endmodule : yuyv_to_rgb888_converter

`default_nettype wire
